@@ rtl/core/min_plus_matrix_power_defines.svh @@
// assertion macros for the min-plus matrix engine
// used by the top level only, no other dependencies
`ifndef MIN_PLUS_MATRIX_POWER_DEFINES_SVH
`define MIN_PLUS_MATRIX_POWER_DEFINES_SVH

// same-cycle implication
`define MPMP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MPMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/mpmp_pkg.sv @@
// shared constants and control types of the min-plus matrix engine
// no dependencies
`default_nettype none

package mpmp_pkg;

    localparam int DEF_MAX_SIZE    = 8;
    localparam int DEF_ENTRY_WIDTH = 32;
    localparam int DEF_SUM_WIDTH   = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int SIZE_W     = 4;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MUL    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIAG   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // operand selection for one product
    typedef struct packed {
        logic left_acc;    // left operand: 0 first matrix, 1 accumulated matrix
        logic right_sec;   // right operand: 0 first matrix, 1 second matrix
    } cell_ctrl_t;

    // write enables of the per-cell operand stores
    typedef struct packed {
        logic lcol0;
        logic lcol1;
        logic rrow0;
        logic rrow1;
    } cell_we_t;

endpackage

`default_nettype wire

@@ rtl/core/mpmp_cell.sv @@
// one cell of the min-plus chain: holds column k of the left operands and
// row k of the right operands, adds one term and folds it into the token
// depends on mpmp_pkg
`default_nettype none

module mpmp_cell
    import mpmp_pkg::*;
#(
    parameter int MAX_SIZE   = DEF_MAX_SIZE,
    parameter int SUM_WIDTH  = DEF_SUM_WIDTH,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                                           aclk,
    input  wire logic                                           aresetn,
    input  wire logic [$clog2(MAX_SIZE+1)-1:0]                  dim_n,
    input  wire cell_ctrl_t                                     ctrl,
    input  wire cell_we_t                                       we,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] wr_row,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] wr_col,
    input  wire logic [SUM_WIDTH+1:0]                           wr_data,
    input  wire logic                                           tin_valid,
    input  wire logic                                           tin_last,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] tin_r,
    input  wire logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0] tin_c,
    input  wire logic [SUM_WIDTH+1:0]                           tin_best,
    output logic                                                tout_valid,
    output logic                                                tout_last,
    output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]  tout_r,
    output logic [((MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1)-1:0]  tout_c,
    output logic [SUM_WIDTH+1:0]                                tout_best
);

    localparam int IW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW = $clog2(MAX_SIZE+1);
    localparam int EW = SUM_WIDTH + 2;
    localparam logic [IW-1:0] K = IW'(CELL_INDEX);
    localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic [EW-1:0] lcol0 [0:MAX_SIZE-1];
    logic [EW-1:0] lcol1 [0:MAX_SIZE-1];
    logic [EW-1:0] rrow0 [0:MAX_SIZE-1];
    logic [EW-1:0] rrow1 [0:MAX_SIZE-1];

    always_ff @(posedge aclk) begin
        if (we.lcol0 && wr_col == K) begin
            lcol0[wr_row] <= wr_data;
        end
        if (we.lcol1 && wr_col == K) begin
            lcol1[wr_row] <= wr_data;
        end
        if (we.rrow0 && wr_row == K) begin
            rrow0[wr_col] <= wr_data;
        end
        if (we.rrow1 && wr_row == K) begin
            rrow1[wr_col] <= wr_data;
        end
    end

    logic                 active;
    logic [EW-1:0]        x_ent, y_ent;
    logic signed [SUM_WIDTH:0] raw_sum;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic                 sum_ovf;

    assign active  = NW'(CELL_INDEX) < dim_n;
    assign x_ent   = ctrl.left_acc  ? lcol1[tin_r] : lcol0[tin_r];
    assign y_ent   = ctrl.right_sec ? rrow1[tin_c] : rrow0[tin_c];
    assign raw_sum = {x_ent[SUM_WIDTH-1], x_ent[SUM_WIDTH-1:0]}
                   + {y_ent[SUM_WIDTH-1], y_ent[SUM_WIDTH-1:0]};
    assign sum_ovf = raw_sum[SUM_WIDTH] != raw_sum[SUM_WIDTH-1];
    assign sum_sat = !sum_ovf ? raw_sum[SUM_WIDTH-1:0] : (raw_sum[SUM_WIDTH] ? SMIN : SMAX);

    // add stage
    logic                 v1_reg, last1_reg, fin1_reg, sat1_reg, oin1_reg;
    logic [IW-1:0]        r1_reg, c1_reg;
    logic [EW-1:0]        best1_reg;
    logic signed [SUM_WIDTH-1:0] s1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= tin_valid;
        end
        last1_reg <= tin_last;
        r1_reg    <= tin_r;
        c1_reg    <= tin_c;
        best1_reg <= tin_best;
        fin1_reg  <= active && !x_ent[SUM_WIDTH] && !y_ent[SUM_WIDTH];
        sat1_reg  <= sum_ovf;
        oin1_reg  <= x_ent[SUM_WIDTH+1] | y_ent[SUM_WIDTH+1];
        s1_reg    <= sum_sat;
    end

    // compare stage
    logic [EW-1:0] best_next;

    always_comb begin
        best_next = best1_reg;
        if (fin1_reg) begin
            best_next[SUM_WIDTH+1] = best1_reg[SUM_WIDTH+1] | sat1_reg | oin1_reg;
            if (best1_reg[SUM_WIDTH] || s1_reg < $signed(best1_reg[SUM_WIDTH-1:0])) begin
                best_next[SUM_WIDTH-1:0] = s1_reg;
                best_next[SUM_WIDTH]     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tout_valid <= 1'b0;
        end else begin
            tout_valid <= v1_reg;
        end
        tout_last <= last1_reg;
        tout_r    <= r1_reg;
        tout_c    <= c1_reg;
        tout_best <= best_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/min_plus_matrix_power.sv @@
// min-plus matrix engine: multiply, power by square-and-multiply, diagonal minimum
// top level; depends on mpmp_pkg, mpmp_cell and min_plus_matrix_power_defines.svh
//
// Use: write matrix_size, mode and exponent on the cfg channel (index 0, 1, 2)
// while the block is idle. Entries enter on the s_ channel in row-major order,
// one transfer per cycle while s_ready is high. Multiply takes 2*n*n entries
// (left, then right matrix), power and diagonal take n*n.
// Each product streams n*n tokens through a chain of MAX_SIZE cells, one per
// cycle; a token passes the add and compare registers of every cell, then a
// sweep copies the product back into the cell stores. A power run takes up to
// two products per exponent bit plus an identity fill. Results leave on the
// m_ channel from an output register, m_last on the final one; each entry is
// read from the accumulated matrix and moved into the output register before
// the next is read. Diagonal mode gives one result once its last entry is in
// and the output register is free. s_ready is low from the last entry of a
// load until the last result is in the output register, so a stalled receiver
// holds the block only there. Reset clears the control state and the registers
// to size 8, multiply mode, exponent 1; the matrix stores need no clearing.
`default_nettype none
`include "min_plus_matrix_power_defines.svh"

module min_plus_matrix_power
    import mpmp_pkg::*;
#(
    parameter int MAX_SIZE    = DEF_MAX_SIZE,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH,
    parameter int SUM_WIDTH   = DEF_SUM_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [ENTRY_WIDTH-1:0] s_entry_value,
    input  wire logic                          s_entry_is_inf,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [SUM_WIDTH-1:0]        m_result_value,
    output logic                               m_result_is_inf,
    output logic                               m_overflow,
    output logic                               m_last
);

    localparam int IW   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW   = $clog2(MAX_SIZE+1);
    localparam int AW   = 2 * IW;
    localparam int EW   = SUM_WIDTH + 2;
    localparam int WIDE = (ENTRY_WIDTH > SUM_WIDTH) ? ENTRY_WIDTH : SUM_WIDTH;
    localparam logic signed [SUM_WIDTH-1:0] SMAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SMIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};
    localparam logic [EW-1:0] INF_ENT = {1'b0, 1'b1, {SUM_WIDTH{1'b0}}};

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_RUN    = 3'd1;
    localparam logic [2:0] ST_COPY   = 3'd2;
    localparam logic [2:0] ST_INIT   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_DIAG   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [CFG_DATA_W-1:0] exp_reg, exp_next;
    logic [CFG_DATA_W-1:0] exp_left_reg, exp_left_next;
    logic [IW-1:0]         cnt_r_reg, cnt_r_next, cnt_c_reg, cnt_c_next;
    logic                  phase_reg, phase_next;
    logic                  go_reg, go_next;
    logic                  did_mul_reg, did_mul_next;
    logic                  dstc_reg, dstc_next;
    cell_ctrl_t            ctrl_reg, ctrl_next;
    logic [EW-1:0]         dbest_reg, dbest_next;
    logic                  cp_v_reg, cp_v_next, cp_last_reg, cp_last_next;
    logic [IW-1:0]         cp_r_reg, cp_r_next, cp_c_reg, cp_c_next;
    logic                  rd_pend_reg, rd_pend_next, rd_last_reg, rd_last_next;
    logic                  m_valid_reg, m_valid_next;
    logic [EW-1:0]         m_ent_reg, m_ent_next;
    logic                  m_last_reg, m_last_next;

    // matrix size in use
    logic [NW-1:0] dim_n;
    logic [IW-1:0] nm1;

    always_comb begin
        if (size_reg == '0) begin
            dim_n = NW'(1);
        end else if ({1'b0, size_reg} > 5'(MAX_SIZE)) begin
            dim_n = NW'(MAX_SIZE);
        end else begin
            dim_n = NW'(size_reg);
        end
    end
    assign nm1 = IW'(dim_n - NW'(1));

    logic          cnt_last;
    logic [IW-1:0] cnt_r_inc, cnt_c_inc;

    assign cnt_last  = (cnt_r_reg == nm1) && (cnt_c_reg == nm1);
    assign cnt_c_inc = (cnt_c_reg == nm1) ? '0 : cnt_c_reg + IW'(1);
    assign cnt_r_inc = (cnt_c_reg == nm1) ? ((cnt_r_reg == nm1) ? '0 : cnt_r_reg + IW'(1))
                                          : cnt_r_reg;

    // entry conversion with saturation to the sum range
    logic signed [WIDE-1:0]      ld_wide;
    logic signed [SUM_WIDTH-1:0] ld_val;
    logic                        ld_ovf;
    logic [EW-1:0]               ld_ent;

    assign ld_wide = WIDE'(s_entry_value);

    always_comb begin
        ld_ovf = 1'b0;
        ld_val = SUM_WIDTH'(ld_wide);
        if (ld_wide > WIDE'(SMAX)) begin
            ld_val = SMAX;
            ld_ovf = 1'b1;
        end else if (ld_wide < WIDE'(SMIN)) begin
            ld_val = SMIN;
            ld_ovf = 1'b1;
        end
        if (s_entry_is_inf) begin
            ld_ent = INF_ENT;
        end else begin
            ld_ent = {ld_ovf, 1'b0, ld_val};
        end
    end

    logic in_fire, out_free;
    assign s_ready   = state_reg == ST_LOAD;
    assign cfg_ready = 1'b1;
    assign in_fire   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // chain of cells
    logic          tv [0:MAX_SIZE];
    logic          tl [0:MAX_SIZE];
    logic [IW-1:0] tr [0:MAX_SIZE];
    logic [IW-1:0] tc [0:MAX_SIZE];
    logic [EW-1:0] tb [0:MAX_SIZE];

    cell_we_t      we;
    logic [IW-1:0] wr_row, wr_col;
    logic [EW-1:0] wr_data;
    logic          acc_we;

    assign tv[0] = (state_reg == ST_RUN) && go_reg;
    assign tl[0] = cnt_last;
    assign tr[0] = cnt_r_reg;
    assign tc[0] = cnt_c_reg;
    assign tb[0] = INF_ENT;

    for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
        mpmp_cell #(
            .MAX_SIZE  (MAX_SIZE),
            .SUM_WIDTH (SUM_WIDTH),
            .CELL_INDEX(k)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .dim_n     (dim_n),
            .ctrl      (ctrl_reg),
            .we        (we),
            .wr_row    (wr_row),
            .wr_col    (wr_col),
            .wr_data   (wr_data),
            .tin_valid (tv[k]),
            .tin_last  (tl[k]),
            .tin_r     (tr[k]),
            .tin_c     (tc[k]),
            .tin_best  (tb[k]),
            .tout_valid(tv[k+1]),
            .tout_last (tl[k+1]),
            .tout_r    (tr[k+1]),
            .tout_c    (tc[k+1]),
            .tout_best (tb[k+1])
        );
    end

    // product scratch and accumulated matrix memories
    logic [EW-1:0] scratch_mem [0:(2**AW)-1];
    logic [EW-1:0] acc_mem     [0:(2**AW)-1];
    logic [EW-1:0] scr_rd_reg, acc_rd_reg;
    logic          scr_rd_en, acc_rd_en;

    assign scr_rd_en = (state_reg == ST_COPY) && go_reg;
    assign acc_rd_en = (state_reg == ST_EMIT) && go_reg && !rd_pend_reg;

    always_ff @(posedge aclk) begin
        if (tv[MAX_SIZE]) begin
            scratch_mem[{tr[MAX_SIZE], tc[MAX_SIZE]}] <= tb[MAX_SIZE];
        end
        if (scr_rd_en) begin
            scr_rd_reg <= scratch_mem[{cnt_r_reg, cnt_c_reg}];
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[{wr_row, wr_col}] <= wr_data;
        end
        if (acc_rd_en) begin
            acc_rd_reg <= acc_mem[{cnt_r_reg, cnt_c_reg}];
        end
    end

    // write bus to the cell stores
    always_comb begin
        we      = '0;
        acc_we  = 1'b0;
        wr_row  = cnt_r_reg;
        wr_col  = cnt_c_reg;
        wr_data = ld_ent;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire && mode_reg != MODE_UNUSED) begin
                    if (mode_reg == MODE_MUL && phase_reg) begin
                        we.rrow1 = 1'b1;
                    end else begin
                        we.lcol0 = 1'b1;
                        we.rrow0 = 1'b1;
                    end
                end
            end
            ST_COPY: begin
                wr_row  = cp_r_reg;
                wr_col  = cp_c_reg;
                wr_data = scr_rd_reg;
                if (cp_v_reg) begin
                    if (dstc_reg) begin
                        we.lcol1 = 1'b1;
                        acc_we   = 1'b1;
                    end else begin
                        we.lcol0 = 1'b1;
                        we.rrow0 = 1'b1;
                    end
                end
            end
            ST_INIT: begin
                wr_data  = {1'b0, cnt_r_reg != cnt_c_reg, {SUM_WIDTH{1'b0}}};
                we.lcol1 = 1'b1;
                acc_we   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    logic [EW-1:0] dbase;

    always_comb begin
        state_next    = state_reg;
        size_next     = size_reg;
        mode_next     = mode_reg;
        exp_next      = exp_reg;
        exp_left_next = exp_left_reg;
        cnt_r_next    = cnt_r_reg;
        cnt_c_next    = cnt_c_reg;
        phase_next    = phase_reg;
        go_next       = go_reg;
        did_mul_next  = did_mul_reg;
        dstc_next     = dstc_reg;
        ctrl_next     = ctrl_reg;
        dbest_next    = dbest_reg;
        cp_v_next     = 1'b0;
        cp_last_next  = 1'b0;
        cp_r_next     = cnt_r_reg;
        cp_c_next     = cnt_c_reg;
        rd_pend_next  = rd_pend_reg;
        rd_last_next  = rd_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_ent_next    = m_ent_reg;
        m_last_next   = m_last_reg;
        dbase         = (cnt_r_reg == '0 && cnt_c_reg == '0) ? INF_ENT : dbest_reg;

        unique case (state_reg)
            ST_LOAD: begin
                if (in_fire && mode_reg != MODE_UNUSED) begin
                    cnt_r_next = cnt_r_inc;
                    cnt_c_next = cnt_c_inc;
                    if (cnt_r_reg == cnt_c_reg && !ld_ent[SUM_WIDTH] &&
                        (dbase[SUM_WIDTH] ||
                         ld_val < $signed(dbase[SUM_WIDTH-1:0]))) begin
                        dbase = ld_ent;
                    end
                    dbest_next = dbase;
                    if (cnt_last) begin
                        if (mode_reg == MODE_MUL) begin
                            phase_next = !phase_reg;
                            if (phase_reg) begin
                                state_next          = ST_RUN;
                                go_next             = 1'b1;
                                ctrl_next.left_acc  = 1'b0;
                                ctrl_next.right_sec = 1'b1;
                                dstc_next           = 1'b1;
                            end
                        end else if (mode_reg == MODE_POW) begin
                            state_next = ST_INIT;
                        end else begin
                            state_next = ST_DIAG;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (go_reg) begin
                    cnt_r_next = cnt_r_inc;
                    cnt_c_next = cnt_c_inc;
                    if (cnt_last) begin
                        go_next = 1'b0;
                    end
                end
                if (tv[MAX_SIZE] && tl[MAX_SIZE]) begin
                    state_next = ST_COPY;
                    go_next    = 1'b1;
                end
            end
            ST_COPY: begin
                if (go_reg) begin
                    cp_v_next    = 1'b1;
                    cp_last_next = cnt_last;
                    cnt_r_next   = cnt_r_inc;
                    cnt_c_next   = cnt_c_inc;
                    if (cnt_last) begin
                        go_next = 1'b0;
                    end
                end
                if (cp_v_reg && cp_last_reg) begin
                    if (mode_reg == MODE_MUL) begin
                        state_next = ST_EMIT;
                        go_next    = 1'b1;
                    end else begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_INIT: begin
                cnt_r_next = cnt_r_inc;
                cnt_c_next = cnt_c_inc;
                if (cnt_last) begin
                    exp_left_next = exp_reg;
                    did_mul_next  = 1'b0;
                    state_next    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (exp_left_reg == '0) begin
                    state_next = ST_EMIT;
                    go_next    = 1'b1;
                end else if (exp_left_reg[0] && !did_mul_reg) begin
                    did_mul_next        = 1'b1;
                    ctrl_next.left_acc  = 1'b1;
                    ctrl_next.right_sec = 1'b0;
                    dstc_next           = 1'b1;
                    state_next          = ST_RUN;
                    go_next             = 1'b1;
                end else begin
                    exp_left_next = exp_left_reg >> 1;
                    did_mul_next  = 1'b0;
                    go_next       = 1'b1;
                    if ((exp_left_reg >> 1) != '0) begin
                        ctrl_next.left_acc  = 1'b0;
                        ctrl_next.right_sec = 1'b0;
                        dstc_next           = 1'b0;
                        state_next          = ST_RUN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (acc_rd_en) begin
                    rd_pend_next = 1'b1;
                    rd_last_next = cnt_last;
                    cnt_r_next   = cnt_r_inc;
                    cnt_c_next   = cnt_c_inc;
                    if (cnt_last) begin
                        go_next = 1'b0;
                    end
                end
                if (rd_pend_reg && out_free) begin
                    rd_pend_next = 1'b0;
                    m_valid_next = 1'b1;
                    m_ent_next   = acc_rd_reg;
                    m_last_next  = rd_last_reg;
                    if (rd_last_reg) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DIAG: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ent_next   = dbest_reg;
                    m_last_next  = 1'b1;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SIZE: begin
                    size_next  = cfg_data[SIZE_W-1:0];
                    cnt_r_next = '0;
                    cnt_c_next = '0;
                    phase_next = 1'b0;
                end
                CFG_MODE: begin
                    mode_next  = cfg_data[MODE_W-1:0];
                    cnt_r_next = '0;
                    cnt_c_next = '0;
                    phase_next = 1'b0;
                end
                CFG_EXP: begin
                    exp_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_W'(8);
            mode_reg     <= MODE_MUL;
            exp_reg      <= CFG_DATA_W'(1);
            exp_left_reg <= '0;
            cnt_r_reg    <= '0;
            cnt_c_reg    <= '0;
            phase_reg    <= 1'b0;
            go_reg       <= 1'b0;
            did_mul_reg  <= 1'b0;
            dstc_reg     <= 1'b0;
            ctrl_reg     <= '0;
            cp_v_reg     <= 1'b0;
            cp_last_reg  <= 1'b0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            mode_reg     <= mode_next;
            exp_reg      <= exp_next;
            exp_left_reg <= exp_left_next;
            cnt_r_reg    <= cnt_r_next;
            cnt_c_reg    <= cnt_c_next;
            phase_reg    <= phase_next;
            go_reg       <= go_next;
            did_mul_reg  <= did_mul_next;
            dstc_reg     <= dstc_next;
            ctrl_reg     <= ctrl_next;
            cp_v_reg     <= cp_v_next;
            cp_last_reg  <= cp_last_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            m_valid_reg  <= m_valid_next;
        end
        dbest_reg  <= dbest_next;
        cp_r_reg   <= cp_r_next;
        cp_c_reg   <= cp_c_next;
        m_ent_reg  <= m_ent_next;
        m_last_reg <= m_last_next;
    end

    // infinite results carry zero value and no overflow
    assign m_valid         = m_valid_reg;
    assign m_result_is_inf = m_ent_reg[SUM_WIDTH];
    assign m_result_value  = m_ent_reg[SUM_WIDTH] ? '0 : m_ent_reg[SUM_WIDTH-1:0];
    assign m_overflow      = !m_ent_reg[SUM_WIDTH] && m_ent_reg[SUM_WIDTH+1];
    assign m_last          = m_last_reg;

    `MPMP_ASSERT_NOW(a_chain_exit_in_run, aclk, aresetn, tv[MAX_SIZE], state_reg == ST_RUN, "token left chain outside a product")
    `MPMP_ASSERT_NEXT(a_last_token_copies, aclk, aresetn, tv[MAX_SIZE] && tl[MAX_SIZE], state_reg == ST_COPY, "no copy after last product entry")
    `MPMP_ASSERT_NOW(a_read_pending_emit, aclk, aresetn, rd_pend_reg, state_reg == ST_EMIT, "result read pending outside emission")

endmodule

`default_nettype wire

@@ verif/tb_min_plus_matrix_power.sv @@
// testbench for min_plus_matrix_power: multiply, power and diagonal-minimum runs
// checked entry by entry against a scoreboard class with its own min-plus predictor
// depends on mpmp_pkg and the min_plus_matrix_power rtl
`default_nettype none

module tb_min_plus_matrix_power;
    import mpmp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CELLS = DEF_MAX_SIZE * DEF_MAX_SIZE;
    localparam longint SUM_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint SUM_MIN = 64'sh8000_0000_0000_0000;
    localparam int SETTLE_CYCLES = 64;

    typedef struct {
        longint val;
        bit     inf;
        bit     ovf;
    } entry_t;

    typedef struct {
        longint val;
        bit     inf;
        bit     ovf;
        bit     last;
    } result_t;

    class mp_scoreboard;
        logic [SIZE_W-1:0] size_reg;
        logic [MODE_W-1:0] mode_reg;
        bit [63:0]         exp_reg;
        int                load_cnt;
        entry_t            lhs[CELLS];
        entry_t            rhs[CELLS];
        entry_t            acc[CELLS];
        result_t           pending_results[$];
        int                errors;
        int                results_seen;

        function void reset_state();
            size_reg = 4'd8;
            mode_reg = MODE_MUL;
            exp_reg = 64'd1;
            load_cnt = 0;
            errors = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE: begin
                    size_reg = data[SIZE_W-1:0];
                    load_cnt = 0;
                end
                CFG_MODE: begin
                    mode_reg = data[MODE_W-1:0];
                    load_cnt = 0;
                end
                CFG_EXP: exp_reg = data;
                default: ;
            endcase
        endfunction

        function int dim();
            if (size_reg == 0) return 1;
            if (size_reg > DEF_MAX_SIZE) return DEF_MAX_SIZE;
            return size_reg;
        endfunction

        function void min_plus(output entry_t d[CELLS], input entry_t a[CELLS],
                               input entry_t b[CELLS], input int n);
            entry_t best;
            entry_t x;
            entry_t y;
            logic signed [64:0] s;
            longint sv;
            bit sat;
            d = a;
            for (int r = 0; r < n; r++) begin
                for (int c = 0; c < n; c++) begin
                    best = '{0, 1'b1, 1'b0};
                    for (int k = 0; k < n; k++) begin
                        x = a[r * n + k];
                        y = b[k * n + c];
                        if (x.inf || y.inf) continue;
                        s = {x.val[63], x.val} + {y.val[63], y.val};
                        sat = s[64] != s[63];
                        sv = sat ? (s[64] ? SUM_MIN : SUM_MAX) : longint'(s[63:0]);
                        best.ovf = best.ovf | sat | x.ovf | y.ovf;
                        if (best.inf || sv < best.val) begin
                            best.val = sv;
                            best.inf = 1'b0;
                        end
                    end
                    d[r * n + c] = best;
                end
            end
        endfunction

        function void push_result(entry_t e, bit last);
            result_t r;
            r.val = e.inf ? 0 : e.val;
            r.inf = e.inf;
            r.ovf = !e.inf && e.ovf;
            r.last = last;
            pending_results = {pending_results, r};
        endfunction

        function void note_entry(logic signed [DEF_ENTRY_WIDTH-1:0] v, bit is_inf);
            int n;
            int nn;
            entry_t e;
            entry_t best;
            bit [63:0] e_left;
            n = dim();
            nn = n * n;
            if (mode_reg == MODE_UNUSED) return;
            e.val = is_inf ? 0 : longint'(v);
            e.inf = is_inf;
            e.ovf = 1'b0;
            if (mode_reg == MODE_MUL) begin
                if (load_cnt < nn) begin
                    lhs[load_cnt++] = e;
                    return;
                end
                rhs[load_cnt - nn] = e;
                load_cnt++;
                if (load_cnt < 2 * nn) return;
                load_cnt = 0;
                min_plus(acc, lhs, rhs, n);
                for (int i = 0; i < nn; i++) push_result(acc[i], i + 1 == nn);
                return;
            end
            if (load_cnt >= nn) load_cnt = 0;
            lhs[load_cnt++] = e;
            if (load_cnt < nn) return;
            load_cnt = 0;
            if (mode_reg == MODE_DIAG) begin
                best = '{0, 1'b1, 1'b0};
                for (int i = 0; i < n; i++)
                    if (!lhs[i * n + i].inf && (best.inf || lhs[i * n + i].val < best.val))
                        best = lhs[i * n + i];
                push_result(best, 1'b1);
                return;
            end
            for (int i = 0; i < nn; i++) acc[i] = '{0, (i % (n + 1)) != 0, 1'b0};
            e_left = exp_reg;
            while (e_left != 0) begin
                if (e_left[0]) min_plus(acc, acc, lhs, n);
                e_left = e_left >> 1;
                if (e_left != 0) min_plus(lhs, lhs, lhs, n);
            end
            for (int i = 0; i < nn; i++) push_result(acc[i], i + 1 == nn);
        endfunction

        function void check_result(longint v, bit is_inf, bit ovf, bit last);
            result_t w;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result value=%0d inf=%0b ovf=%0b last=%0b",
                         $time, v, is_inf, ovf, last);
                errors++;
                return;
            end
            w = pending_results.pop_front();
            if (w.val != v || w.inf != is_inf || w.ovf != ovf || w.last != last) begin
                $display("%0t: result mismatch expected value=%0d inf=%0b ovf=%0b last=%0b",
                         $time, w.val, w.inf, w.ovf, w.last);
                $display("%0t:                 actual   value=%0d inf=%0b ovf=%0b last=%0b",
                         $time, v, is_inf, ovf, last);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [DEF_ENTRY_WIDTH-1:0] s_entry_value;
    logic s_entry_is_inf;
    logic m_valid;
    logic m_ready;
    logic signed [DEF_SUM_WIDTH-1:0] m_result_value;
    logic m_result_is_inf;
    logic m_overflow;
    logic m_last;

    mp_scoreboard sb;
    int burst_left;
    bit gaps_on;
    int stall_style;
    int entries_sent;
    int loads_done;

    min_plus_matrix_power dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_entry_value(s_entry_value),
        .s_entry_is_inf(s_entry_is_inf),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_value(m_result_value),
        .m_result_is_inf(m_result_is_inf),
        .m_overflow(m_overflow),
        .m_last(m_last)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(negedge aclk) begin
        case (stall_style)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 2) != 0);
            default: m_ready <= (($time / 2) % 23) < 12;
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result_value, m_result_is_inf, m_overflow, m_last);
    end

    initial begin
        #10000000;
        $display("min_plus_matrix_power verification failed");
        $finish;
    end

    // every task starts and ends just after a falling edge
    task automatic put_entry(logic signed [DEF_ENTRY_WIDTH-1:0] v, bit is_inf);
        if (gaps_on && burst_left == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        s_valid = 1'b1;
        s_entry_value = v;
        s_entry_is_inf = is_inf;
        do @(posedge aclk); while (!s_ready);
        sb.note_entry(v, is_inf);
        entries_sent++;
        if (burst_left > 0) burst_left--;
        @(negedge aclk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        s_valid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // upper data bits are don't-care for the narrow registers
    task automatic setup(int size, logic [MODE_W-1:0] md, bit [63:0] ex);
        write_cfg(CFG_SIZE, {$urandom, $urandom} & ~64'hf | 64'(size));
        write_cfg(CFG_MODE, {$urandom, $urandom} & ~64'h3 | 64'(md));
        write_cfg(CFG_EXP, ex);
    endtask

    function automatic logic signed [DEF_ENTRY_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2, 3: return $urandom;
            default: return $signed(32'($urandom_range(0, 200))) - 100;
        endcase
    endfunction

    task automatic send_load(int count);
        for (int i = 0; i < count; i++) put_entry(rand_value(), $urandom_range(0, 4) == 0);
        loads_done++;
    endtask

    int n;
    int md;
    bit [63:0] ex;

    initial begin
        sb = new();
        sb.reset_state();
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SIZE;
        cfg_data = '0;
        s_valid = 1'b0;
        s_entry_value = '0;
        s_entry_is_inf = 1'b0;
        m_ready = 1'b0;
        stall_style = 0;
        gaps_on = 1'b0;
        burst_left = 0;
        entries_sent = 0;
        loads_done = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // extremes through a 2x2 product
        setup(2, MODE_MUL, 64'd1);
        put_entry(32'sh7fff_ffff, 1'b0);
        put_entry(32'sh8000_0000, 1'b0);
        put_entry(32'sh1234_5678, 1'b1);
        put_entry(32'sd0, 1'b0);
        put_entry(32'sh7fff_ffff, 1'b0);
        put_entry(32'sd0, 1'b1);
        put_entry(32'sh8000_0000, 1'b0);
        put_entry(-32'sd1, 1'b1);
        wait_idle();
        // diagonal with an infinite entry on the diagonal
        setup(3, MODE_DIAG, 64'd1);
        for (int i = 0; i < 9; i++) put_entry(-32'sd5 * i, i == 0);
        wait_idle();
        // power with zero exponent gives the identity
        setup(2, MODE_POW, 64'd0);
        for (int i = 0; i < 4; i++) put_entry(32'sd7, 1'b0);
        wait_idle();
        // huge exponent drives the sums into saturation
        write_cfg(CFG_EXP, '1);
        put_entry(-32'sd3, 1'b0);
        put_entry(32'sd1, 1'b1);
        put_entry(32'sd4, 1'b0);
        put_entry(32'sh7fff_ffff, 1'b0);
        wait_idle();
        // size zero acts as one, size above the maximum as the maximum
        setup(0, MODE_DIAG, 64'd1);
        put_entry(32'sh8000_0000, 1'b0);
        wait_idle();
        setup(15, MODE_DIAG, 64'd1);
        send_load(64);
        wait_idle();
        // unused mode and unused register index are ignored
        write_cfg(CFG_MODE, 64'(MODE_UNUSED));
        write_cfg(CFG_UNUSED, '1);
        for (int i = 0; i < 3; i++) put_entry(rand_value(), 1'b0);
        wait_idle();
        // partial load dropped by reconfiguration
        setup(2, MODE_MUL, 64'd1);
        for (int i = 0; i < 3; i++) put_entry(rand_value(), 1'b0);
        wait_idle();
        write_cfg(CFG_SIZE, 64'd2);
        send_load(8);
        wait_idle();

        while (entries_sent < 210) begin
            stall_style = $urandom_range(0, 2);
            gaps_on = $urandom_range(0, 2) != 0;
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 3);
            md = $urandom_range(0, 2);
            ex = $urandom_range(0, 20);
            if (n <= 3 && $urandom_range(0, 3) == 0) ex = {$urandom, $urandom};
            setup(n, md, ex);
            repeat ($urandom_range(1, 2)) send_load((md == MODE_MUL ? 2 : 1) * n * n);
            if ($urandom_range(0, 7) == 0) begin
                put_entry(rand_value(), 1'b0);
                wait_idle();
                write_cfg(CFG_MODE, 64'(md));
                send_load((md == MODE_MUL ? 2 : 1) * n * n);
            end
            wait_idle();
        end

        wait_idle();
        $display("covered %0d entries in %0d loads, %0d results checked",
                 entries_sent, loads_done, sb.results_seen);
        $display("modes multiply, power and diagonal at sizes 0 to 15, with stalls and gaps");
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("min_plus_matrix_power verification clean");
        end else begin
            $display("min_plus_matrix_power verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
